@@ src/cst_pkg.sv @@
// ---------------------------------------------------------------------------
// cst_pkg - shared definitions for the comment stripping tokenizer
// Character codes, token class and error codes, lexer state encodings and
// character classification helpers.
// ---------------------------------------------------------------------------
package cst_pkg;

	// default widths
	localparam int CST_INT_BITS  = 32;
	localparam int CST_LINE_BITS = 24;

	// results one input byte can cause
	localparam int MAX_RES = 4;

	// token classes
	localparam logic [2:0] CLS_PUNCT  = 3'd0;
	localparam logic [2:0] CLS_INT    = 3'd1;
	localparam logic [2:0] CLS_REAL   = 3'd2;
	localparam logic [2:0] CLS_WORD   = 3'd3;
	localparam logic [2:0] CLS_STRING = 3'd4;
	localparam logic [2:0] CLS_END    = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN    = 2'd1;
	localparam logic [1:0] ERR_LINE_OPEN  = 2'd2;
	localparam logic [1:0] ERR_BLOCK_OPEN = 2'd3;

	// characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// lexer mode
	typedef enum logic [2:0] {
		MODE_EMPTY  = 3'b001,
		MODE_BLOB   = 3'b010,
		MODE_STRING = 3'b100
	} lex_mode_t;

	// number shape recognizer
	typedef enum logic [5:0] {
		SH_START = 6'b000001,
		SH_SIGN  = 6'b000010,
		SH_INT   = 6'b000100,
		SH_DOT   = 6'b001000,
		SH_FRAC  = 6'b010000,
		SH_WORD  = 6'b100000
	} shape_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_blob(logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
			is_digit(c) || (c == CH_UNDER) || (c == CH_MINUS) || (c == CH_PLUS) ||
			(c == CH_DOT);
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return (c == CH_SEMI) || (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAR) ||
			(c == CH_RPAR) || (c == CH_LT) || (c == CH_GT);
	endfunction

endpackage

@@ src/comment_strip_tokenizer.sv @@
// ---------------------------------------------------------------------------
// comment_strip_tokenizer - text lexer with comment removal
// Strips line and block comments from a byte stream and splits the rest
// into punctuation, blob (integer, real, word) and quoted string tokens.
// ---------------------------------------------------------------------------
//
// Usage
//   Input stream s_*: one text character per request in s_tdata[7:0];
//   s_tlast marks the final character of the text. That character flushes
//   held bytes, finishes an open blob, reports an open comment and closes
//   with an end token (class 5); the lexer then starts over from reset.
//   Output stream m_*: one token character per request. m_tlast marks the
//   last character of a token, where class, integer value and overflow are
//   valid; skipped input bytes produce no output.
//   Path: a character is registered at s1, run through the whole lexer
//   combinationally and its results are registered in the result buffer
//   that drives m_*.
//   Throughput: one character per cycle while each character yields at most
//   one result and m_tready stays high. A character with several results (up
//   to four, mostly at token ends and at end of text) holds the input until
//   the single-read buffer, draining one entry per cycle, is at its last entry.
//   A stalled receiver holds the result buffer; the input register still
//   takes one more character before s_tready drops.
//   Reset (arst_n low) clears all lexer state, line count back to one.
//
module comment_strip_tokenizer
	import cst_pkg::*;
#(
	parameter int INT_BITS  = CST_INT_BITS,
	parameter int LINE_BITS = CST_LINE_BITS,
	localparam int TDATA_W  = ((8 + INT_BITS + LINE_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// input characters
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // end_of_text
	// token characters
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // token_byte, int_value, line_number, zero pad
	output logic               m_tlast,   // last_of_token
	output logic [7:0]         m_tuser    // first_of_token, token_class[2:0],
	                                      // int_overflow, error_code[1:0], zero
);

	localparam int IDX_W = $clog2(MAX_RES);
	localparam int CNT_W = $clog2(MAX_RES + 1);

	localparam logic [INT_BITS-1:0]  HALF    = {1'b1, {(INT_BITS-1){1'b0}}};
	localparam logic [INT_BITS-1:0]  HALF_M1 = HALF - 1'b1;
	localparam logic [INT_BITS-1:0]  LIMIT   = HALF + 1'b1;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

	typedef struct packed {
		logic                  lh;      // line stage holds a '/'
		logic                  in_lc;   // inside // comment
		logic                  bh;      // block stage holds '/' (or '*' inside comment)
		logic                  in_bc;   // inside block comment
		lex_mode_t             mode;
		shape_t                shape;
		logic [INT_BITS-1:0]   acc;     // integer magnitude, clamps at LIMIT
		logic [7:0]            pend;    // held blob byte
		logic                  pfirst;
		logic                  neg;
		logic [LINE_BITS-1:0]  line;
	} state_t;

	typedef struct packed {
		logic [7:0]           tbyte;
		logic                 first;
		logic                 last;
		logic [2:0]           cls;
		logic [INT_BITS-1:0]  val;
		logic                 ovf;
		logic [1:0]           err;
		logic [LINE_BITS-1:0] line;
	} res_t;

	typedef struct packed {
		state_t                   st;
		res_t [MAX_RES-1:0]       res;
		logic [CNT_W-1:0]         n;
	} ctx_t;

	localparam state_t ST_RESET = '{
		lh: 1'b0, in_lc: 1'b0, bh: 1'b0, in_bc: 1'b0,
		mode: MODE_EMPTY, shape: SH_START, acc: '0, pend: '0,
		pfirst: 1'b0, neg: 1'b0, line: LINE_BITS'(1)
	};

	// ---- lexer step functions --------------------------------------------

	// append one result; extras past MAX_RES are dropped
	function automatic ctx_t f_emit(ctx_t x, logic [7:0] b, logic fi, logic la,
			logic [2:0] cl, logic [INT_BITS-1:0] v, logic ov, logic [1:0] er);
		ctx_t y;
		res_t r;
		y = x;
		r.tbyte = b;
		r.first = fi;
		r.last  = la;
		r.cls   = cl;
		r.val   = v;
		r.ovf   = ov;
		r.err   = er;
		r.line  = x.st.line;
		if (x.n < CNT_W'(MAX_RES)) begin
			y.res[x.n[IDX_W-1:0]] = r;
			y.n = x.n + 1'b1;
		end
		return y;
	endfunction

	function automatic ctx_t f_line_inc(ctx_t x);
		ctx_t y;
		y = x;
		if (x.st.line != LINE_MAX)
			y.st.line = x.st.line + 1'b1;
		return y;
	endfunction

	// times ten plus digit, clamped; wide enough for LIMIT * 10 + 9
	function automatic logic [INT_BITS-1:0] f_add_digit(logic [INT_BITS-1:0] a,
			logic [3:0] d);
		logic [INT_BITS+4:0] w;
		w = ((INT_BITS+5)'(a) << 3) + ((INT_BITS+5)'(a) << 1) + (INT_BITS+5)'(d);
		if (w > (INT_BITS+5)'(LIMIT))
			return LIMIT;
		return w[INT_BITS-1:0];
	endfunction

	function automatic ctx_t f_shape_step(ctx_t x, logic [7:0] c);
		ctx_t y;
		logic dig;
		y = x;
		dig = is_digit(c);
		unique case (x.st.shape)
			SH_START, SH_SIGN, SH_INT: begin
				if ((x.st.shape == SH_START) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
					y.st.shape = SH_SIGN;
					y.st.neg = (c == CH_MINUS);
				end else if (dig) begin
					y.st.shape = SH_INT;
					y.st.acc = f_add_digit(x.st.acc, c[3:0]);
				end else if (c == CH_DOT) begin
					y.st.shape = SH_DOT;
				end else begin
					y.st.shape = SH_WORD;
				end
			end
			SH_DOT, SH_FRAC: y.st.shape = dig ? SH_FRAC : SH_WORD;
			default: y.st.shape = SH_WORD;
		endcase
		return y;
	endfunction

	function automatic ctx_t f_finish_blob(ctx_t x);
		ctx_t y;
		logic [2:0] cl;
		logic [INT_BITS-1:0] mag;
		logic [INT_BITS-1:0] v;
		logic ov;
		cl = CLS_WORD;
		v = '0;
		ov = 1'b0;
		mag = x.st.acc;
		if (x.st.shape == SH_INT) begin
			cl = CLS_INT;
			if (x.st.neg) begin
				if (mag > HALF) begin
					ov = 1'b1;
					mag = HALF;
				end
				v = -mag;
			end else begin
				if (mag > HALF_M1) begin
					ov = 1'b1;
					mag = HALF_M1;
				end
				v = mag;
			end
		end else if (x.st.shape == SH_FRAC) begin
			cl = CLS_REAL;
		end
		y = f_emit(x, x.st.pend, x.st.pfirst, 1'b1, cl, v, ov, ERR_NONE);
		y.st.mode = MODE_EMPTY;
		y.st.pend = '0;
		y.st.pfirst = 1'b0;
		return y;
	endfunction

	function automatic ctx_t f_tok(ctx_t x, logic [7:0] c);
		ctx_t y;
		logic cls_q;
		y = x;
		if (y.st.mode == MODE_BLOB) begin
			if (is_blob(c)) begin
				// previous held byte is not the last one
				y = f_emit(y, y.st.pend, y.st.pfirst, 1'b0, CLS_PUNCT, '0, 1'b0, ERR_NONE);
				y.st.pend = c;
				y.st.pfirst = 1'b0;
				return f_shape_step(y, c);
			end
			y = f_finish_blob(y);
		end
		if (y.st.mode == MODE_STRING) begin
			cls_q = (c == CH_QUOTE);
			y = f_emit(y, c, 1'b0, cls_q, cls_q ? CLS_STRING : CLS_PUNCT, '0, 1'b0,
				ERR_NONE);
			if (c == CH_LF)
				y = f_line_inc(y);
			if (cls_q)
				y.st.mode = MODE_EMPTY;
			return y;
		end
		y.st.mode = MODE_EMPTY;
		if ((c == CH_SP) || (c == CH_TAB))
			return y;
		if (c == CH_LF)
			return f_line_inc(y);
		if (is_blob(c)) begin
			y.st.mode = MODE_BLOB;
			y.st.pend = c;
			y.st.pfirst = 1'b1;
			y.st.shape = SH_START;
			y.st.acc = '0;
			y.st.neg = 1'b0;
			y = f_shape_step(y, c);
		end else if (is_punct(c)) begin
			y = f_emit(y, c, 1'b1, 1'b1, CLS_PUNCT, '0, 1'b0, ERR_NONE);
		end else if (c == CH_QUOTE) begin
			y = f_emit(y, c, 1'b1, 1'b0, CLS_PUNCT, '0, 1'b0, ERR_NONE);
			y.st.mode = MODE_STRING;
		end else begin
			y = f_emit(y, c, 1'b0, 1'b0, CLS_PUNCT, '0, 1'b0, ERR_UNKNOWN);
		end
		return y;
	endfunction

	// block comment stage
	function automatic ctx_t f_block(ctx_t x, logic [7:0] c);
		ctx_t y;
		y = x;
		if (x.st.in_bc) begin
			if (c == CH_LF) begin
				y.st.bh = 1'b0;
				return f_tok(y, CH_LF);
			end
			if (x.st.bh && (c == CH_SLASH)) begin
				y.st.in_bc = 1'b0;
				y.st.bh = 1'b0;
				return y;
			end
			y.st.bh = (c == CH_STAR);
			return y;
		end
		if (x.st.bh) begin
			y.st.bh = 1'b0;
			if (c == CH_STAR) begin
				y.st.in_bc = 1'b1;
				return y;
			end
			y = f_tok(y, CH_SLASH);
		end
		if (c == CH_SLASH)
			y.st.bh = 1'b1;
		else
			y = f_tok(y, c);
		return y;
	endfunction

	// line comment stage
	function automatic ctx_t f_line(ctx_t x, logic [7:0] c);
		ctx_t y;
		y = x;
		if (x.st.in_lc) begin
			if (c == CH_LF) begin
				y.st.in_lc = 1'b0;
				y = f_block(y, CH_LF);
			end
			return y;
		end
		if (x.st.lh) begin
			y.st.lh = 1'b0;
			if (c == CH_SLASH) begin
				y.st.in_lc = 1'b1;
				return y;
			end
			y = f_block(y, CH_SLASH);
		end
		if (c == CH_SLASH)
			y.st.lh = 1'b1;
		else
			y = f_block(y, c);
		return y;
	endfunction

	// ---- registers -------------------------------------------------------

	logic                     in_vld_s1;
	logic [7:0]               in_byte_s1;
	logic                     in_eot_s1;
	state_t                   st_q;
	res_t [MAX_RES-1:0]       buf_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         rd_q;

	ctx_t                     step;
	logic [1:0]               eot_err;
	logic                     drain;
	logic                     process;
	res_t                     cur;

	// the buffer can take a new batch once it is empty or its last entry leaves
	assign drain    = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_tready);
	assign process  = in_vld_s1 && drain;
	assign s_tready = !in_vld_s1 || process;

	// whole lexer step for the registered character
	always_comb begin
		step = '0;
		step.st = st_q;
		eot_err = ERR_NONE;
		step = f_line(step, in_byte_s1);
		if (in_eot_s1) begin
			// flush in stage order, then report and close
			if (step.st.in_lc)
				eot_err = ERR_LINE_OPEN;
			else if (step.st.lh)
				step = f_block(step, CH_SLASH);
			step.st.lh = 1'b0;
			if (step.st.in_bc) begin
				if (eot_err == ERR_NONE)
					eot_err = ERR_BLOCK_OPEN;
			end else if (step.st.bh) begin
				step = f_tok(step, CH_SLASH);
			end
			step.st.bh = 1'b0;
			if (step.st.mode == MODE_BLOB)
				step = f_finish_blob(step);
			if (eot_err != ERR_NONE)
				step = f_emit(step, '0, 1'b0, 1'b0, CLS_PUNCT, '0, 1'b0, eot_err);
			step = f_emit(step, '0, 1'b1, 1'b1, CLS_END, '0, 1'b0, ERR_NONE);
			step.st = ST_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
			st_q      <= ST_RESET;
			cnt_q     <= '0;
			rd_q      <= '0;
		end else begin
			if (s_tvalid && s_tready)
				in_vld_s1 <= 1'b1;
			else if (process)
				in_vld_s1 <= 1'b0;
			if (process) begin
				st_q  <= step.st;
				cnt_q <= step.n;
				rd_q  <= '0;
			end else if (m_tvalid && m_tready) begin
				cnt_q <= cnt_q - 1'b1;
				rd_q  <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_eot_s1  <= s_tlast;
		end
		if (process)
			buf_q <= step.res;
	end

	// ---- output ----------------------------------------------------------

	assign cur      = buf_q[rd_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = TDATA_W'({cur.line, cur.val, cur.tbyte});
	assign m_tlast  = cur.last;
	assign m_tuser  = {1'b0, cur.err, cur.ovf, cur.cls, cur.first};

	// ---- assertions ------------------------------------------------------

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("result count beyond buffer depth");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.line != '0)
		else $error("line count reached zero");

	a_line_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.lh && st_q.in_lc))
		else $error("held slash inside line comment");

	a_eot_emits: assert property (@(posedge clk) disable iff (!arst_n)
		process && in_eot_s1 |-> step.n != '0)
		else $error("end of text without end token");

	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		process && in_eot_s1 |=> st_q.line == LINE_BITS'(1) && st_q.mode == MODE_EMPTY)
		else $error("lexer state not cleared after end of text");

endmodule
